@@ sv/mpa_pkg.sv @@
// Package for the multi-pattern automaton: field widths, action codes and default sizes.
package mpa_pkg;

   localparam int unsigned MAX_NODES_DEF    = 1024;
   localparam int unsigned SYMBOL_COUNT_DEF = 16;

   localparam int unsigned ACT_W      = 2;
   localparam int unsigned SYM_W      = 4;
   localparam int unsigned NODE_W     = 10;
   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned RSP_DATA_W = 16;
   // wide enough to compare a 10-bit node against any node count
   localparam int unsigned CMP_W      = 17;
   localparam int unsigned SYMC_W     = 9;

   localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACT_W-1:0] ACT_BUILD  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;

endpackage

@@ sv/multi_pattern_automaton_unit.sv @@
// Aho-Corasick automaton: trie insert, failure link build and transition query.
// Insert reads the child slot, then follows or adds the child; query walks failure links.
// Build: visits every (node, symbol) slot of each queued node, with one failure walk per
// child of a non-root node; it is bound by the single child-table port.
// One item at a time; the next is taken once the result is in the output register.
// Reset: synchronous; then a clearing pass over every child-table slot, taking no item.
module multi_pattern_automaton_unit
   import mpa_pkg::*;
#(
   parameter int unsigned MAX_NODES    = MAX_NODES_DEF,
   parameter int unsigned SYMBOL_COUNT = SYMBOL_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // symbol[3:0], from_node[13:4], zero pad
   input  logic [ACT_W-1:0]      req_tuser,   // action
   input  logic                  req_tlast,   // last_of_pattern
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // next_node[9:0], is_match[10], table_full[11]
);

   localparam int unsigned NW    = $clog2(MAX_NODES);
   localparam int unsigned SW    = $clog2(SYMBOL_COUNT);
   localparam int unsigned AW    = NW + SW;
   localparam int unsigned CDEP  = 1 << AW;
   localparam int unsigned NDEP  = 1 << NW;

   localparam logic [3:0] S_CLR   = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_INS_RD = 4'd2;
   localparam logic [3:0] S_INS_EV = 4'd3;
   localparam logic [3:0] S_M_RD  = 4'd4;
   localparam logic [3:0] S_M_Q   = 4'd5;
   localparam logic [3:0] S_W_RD  = 4'd6;
   localparam logic [3:0] S_W_EV  = 4'd7;
   localparam logic [3:0] S_B_RD  = 4'd8;
   localparam logic [3:0] S_B_EV  = 4'd9;
   localparam logic [3:0] S_B_PE  = 4'd10;
   localparam logic [3:0] S_B_PEQ = 4'd11;
   localparam logic [3:0] S_B_DQ  = 4'd12;
   localparam logic [3:0] S_B_DQQ = 4'd13;
   localparam logic [3:0] S_FIN   = 4'd14;

   localparam logic [NW:0]   MAXN  = (NW+1)'(MAX_NODES);
   localparam logic [SW-1:0] SLAST = SW'(SYMBOL_COUNT - 1);

   // child table: 0 means no child (the root is never a child)
   logic [NW-1:0] child_mem [CDEP];
   logic [NW-1:0] link_mem  [NDEP];
   logic          pe_mem    [NDEP];
   logic [NW-1:0] queue_mem [NDEP];

   logic [NW-1:0] child_q, link_q, queue_q;
   logic          pe_q;

   logic          child_we, link_we, pe_we, queue_we;
   logic [AW-1:0] child_wa, child_ra;
   logic [NW-1:0] child_wd, link_wa, link_wd, link_ra, pe_wa, pe_ra;
   logic [NW-1:0] queue_wa, queue_wd, queue_ra;
   logic          pe_wd;

   logic [3:0]      state_ff, state_in;
   logic [ACT_W-1:0] act_ff, act_in;
   logic [SW-1:0]   sym_ff, sym_in;
   logic            sym_ok_ff, sym_ok_in;
   logic            last_ff, last_in;
   logic [NW-1:0]   cursor_ff, cursor_in;
   logic [NW:0]     nodes_ff, nodes_in;
   logic [NW-1:0]   wcur_ff, wcur_in;
   logic [NW:0]     steps_ff, steps_in;
   logic            wret_ff, wret_in;
   logic [NW-1:0]   bcur_ff, bcur_in;
   logic [SW-1:0]   bs_ff, bs_in;
   logic            root_ff, root_in;
   logic [NW:0]     head_ff, head_in, tail_ff, tail_in;
   logic [NW-1:0]   cnode_ff, cnode_in, k_ff, k_in;
   logic [NW-1:0]   res_node_ff, res_node_in;
   logic            res_match_ff, res_match_in, res_full_ff, res_full_in;
   logic [AW-1:0]   clr_ff, clr_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [SYM_W-1:0]  req_sym;
   logic [NODE_W-1:0] req_from;
   logic              req_sym_ok, req_from_ok, fire;
   logic              ch_ok, link_ok;

   assign req_sym     = req_tdata[3:0];
   assign req_from    = req_tdata[13:4];
   assign req_sym_ok  = SYMC_W'(req_sym) < SYMC_W'(SYMBOL_COUNT);
   assign req_from_ok = CMP_W'(req_from) < CMP_W'(nodes_ff);
   assign req_tready  = (state_ff == S_IDLE);
   assign fire        = req_tvalid && req_tready;
   assign link_ok     = (NW+1)'(link_q) < nodes_ff;
   assign ch_ok       = (child_q != '0) && (tail_ff < MAXN);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in = state_ff; act_in = act_ff; sym_in = sym_ff; sym_ok_in = sym_ok_ff;
      last_in = last_ff; cursor_in = cursor_ff; nodes_in = nodes_ff; wcur_in = wcur_ff;
      steps_in = steps_ff; wret_in = wret_ff; bcur_in = bcur_ff; bs_in = bs_ff;
      root_in = root_ff; head_in = head_ff; tail_in = tail_ff; cnode_in = cnode_ff;
      k_in = k_ff; res_node_in = res_node_ff; res_match_in = res_match_ff;
      res_full_in = res_full_ff; clr_in = clr_ff; rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;

      child_we = 1'b0; child_wa = {cursor_ff, sym_ff}; child_wd = nodes_ff[NW-1:0];
      child_ra = {cursor_ff, sym_ff};
      link_we = 1'b0; link_wa = '0; link_wd = '0; link_ra = bcur_ff;
      pe_we = 1'b0; pe_wa = res_node_ff; pe_wd = 1'b1; pe_ra = res_node_ff;
      queue_we = 1'b0; queue_wa = tail_ff[NW-1:0]; queue_wd = cnode_ff;
      queue_ra = head_ff[NW-1:0];

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLR: begin
            child_we = 1'b1; child_wa = clr_ff; child_wd = '0;
            pe_we = 1'b1; pe_wa = clr_ff[NW-1:0]; pe_wd = 1'b0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(CDEP - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (fire) begin
               act_in = req_tuser; sym_in = SW'(req_sym); sym_ok_in = req_sym_ok;
               last_in = req_tlast;
               res_node_in = '0; res_match_in = 1'b0; res_full_in = 1'b0;
               case (req_tuser)
                  ACT_INSERT: state_in = S_INS_RD;
                  ACT_BUILD: begin
                     link_we = 1'b1; link_wa = '0; link_wd = '0;
                     head_in = '0; tail_in = '0; bcur_in = '0; root_in = 1'b1;
                     bs_in = '0; state_in = S_B_RD;
                  end
                  ACT_QUERY: begin
                     wret_in = 1'b0; steps_in = '0;
                     wcur_in = NW'(req_from);
                     state_in = (req_sym_ok && req_from_ok) ? S_W_RD : S_M_RD;
                  end
                  default: state_in = S_FIN;
               endcase
            end
         end
         S_INS_RD: begin
            state_in = S_INS_EV;
         end
         S_INS_EV: begin
            if (sym_ok_ff && child_q != '0) begin
               res_node_in = child_q;
               cursor_in   = last_ff ? '0 : child_q;
               if (last_ff) begin
                  pe_we = 1'b1; pe_wa = child_q; pe_wd = 1'b1;
               end
            end else if (sym_ok_ff && nodes_ff < MAXN) begin
               child_we = 1'b1;
               link_we = 1'b1; link_wa = nodes_ff[NW-1:0]; link_wd = '0;
               pe_we = 1'b1; pe_wa = nodes_ff[NW-1:0]; pe_wd = last_ff;
               nodes_in    = nodes_ff + 1'b1;
               res_node_in = nodes_ff[NW-1:0];
               cursor_in   = last_ff ? '0 : nodes_ff[NW-1:0];
            end else begin
               res_full_in = sym_ok_ff;
               res_node_in = cursor_ff;
               cursor_in   = last_ff ? '0 : cursor_ff;
            end
            state_in = S_M_RD;
         end
         S_M_RD: begin
            state_in = S_M_Q;
         end
         S_M_Q: begin
            res_match_in = pe_q;
            state_in = S_FIN;
         end
         S_W_RD: begin
            child_ra = {wcur_ff, sym_ff};
            link_ra  = wcur_ff;
            state_in = S_W_EV;
         end
         S_W_EV: begin
            if (child_q != '0 || wcur_ff == '0 || steps_ff == MAXN) begin
               // child found, or walk ended without one
               if (wret_ff) begin
                  k_in = child_q; state_in = S_B_PE;
               end else begin
                  res_node_in = child_q; state_in = S_M_RD;
               end
            end else begin
               wcur_in  = link_ok ? link_q : '0;
               steps_in = steps_ff + 1'b1;
               state_in = S_W_RD;
            end
         end
         S_B_RD: begin
            child_ra = {bcur_ff, bs_ff};
            link_ra  = bcur_ff;
            state_in = S_B_EV;
         end
         S_B_EV: begin
            if (ch_ok) begin
               cnode_in = child_q;
               if (root_ff || !link_ok) begin
                  k_in = '0; state_in = S_B_PE;
               end else begin
                  wcur_in = link_q; steps_in = '0; sym_in = bs_ff; wret_in = 1'b1;
                  state_in = S_W_RD;
               end
            end else if (bs_ff != SLAST) begin
               bs_in = bs_ff + 1'b1; state_in = S_B_RD;
            end else begin
               state_in = (head_ff < tail_ff) ? S_B_DQ : S_FIN;
            end
         end
         S_B_PE: begin
            pe_ra = k_ff;
            link_we = 1'b1; link_wa = cnode_ff; link_wd = k_ff;
            queue_we = 1'b1;
            tail_in = tail_ff + 1'b1;
            state_in = S_B_PEQ;
         end
         S_B_PEQ: begin
            if (pe_q) begin
               pe_we = 1'b1; pe_wa = cnode_ff; pe_wd = 1'b1;
            end
            if (bs_ff != SLAST) begin
               bs_in = bs_ff + 1'b1; state_in = S_B_RD;
            end else begin
               state_in = (head_ff < tail_ff) ? S_B_DQ : S_FIN;
            end
         end
         S_B_DQ: begin
            head_in = head_ff + 1'b1;
            state_in = S_B_DQQ;
         end
         S_B_DQQ: begin
            bcur_in = queue_q; root_in = 1'b0; bs_in = '0;
            state_in = S_B_RD;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'd0, res_full_ff, res_match_ff, NODE_W'(res_node_ff)};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (child_we) begin
         child_mem[child_wa] <= child_wd;
      end
      child_q <= child_mem[child_ra];
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      link_q <= link_mem[link_ra];
   end

   always_ff @(posedge clock) begin
      if (pe_we) begin
         pe_mem[pe_wa] <= pe_wd;
      end
      pe_q <= pe_mem[pe_ra];
   end

   always_ff @(posedge clock) begin
      if (queue_we) begin
         queue_mem[queue_wa] <= queue_wd;
      end
      queue_q <= queue_mem[queue_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         nodes_ff     <= (NW+1)'(1);
         cursor_ff    <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         nodes_ff     <= nodes_in;
         cursor_ff    <= cursor_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      sym_ff       <= sym_in;
      sym_ok_ff    <= sym_ok_in;
      last_ff      <= last_in;
      wcur_ff      <= wcur_in;
      steps_ff     <= steps_in;
      wret_ff      <= wret_in;
      bcur_ff      <= bcur_in;
      bs_ff        <= bs_in;
      root_ff      <= root_in;
      cnode_ff     <= cnode_in;
      k_ff         <= k_in;
      res_node_ff  <= res_node_in;
      res_match_ff <= res_match_in;
      res_full_ff  <= res_full_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // a table-full flag only ever comes from an insert
   a_full_insert: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && res_full_ff) |-> (act_ff == ACT_INSERT))
      else $error("table full on a non-insert item");

   a_nodes_range: assert property (@(posedge clock) disable iff (reset)
      (nodes_ff != '0) && (nodes_ff <= MAXN))
      else $error("node count out of range");

   a_cursor_used: assert property (@(posedge clock) disable iff (reset)
      (NW+1)'(cursor_ff) < nodes_ff)
      else $error("insert cursor beyond allocated nodes");

   a_queue_order: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff)
      else $error("build queue head passed tail");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLR) |-> !req_tready)
      else $error("item taken during clearing pass");

endmodule

@@ test/tb_multi_pattern_automaton_unit.sv @@
// Testbench for multi_pattern_automaton_unit: directed and random streams checked against a behavioural trie model.
`timescale 1ns / 1ps

module tb_multi_pattern_automaton_unit;
   import mpa_pkg::*;

   localparam int unsigned NODES = MAX_NODES_DEF;
   localparam int unsigned SYMS  = SYMBOL_COUNT_DEF;
   localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
   localparam int unsigned RANDOM_ITEMS = 1650;

   typedef struct packed {
      logic              full;
      logic              match;
      logic [NODE_W-1:0] node;
   } automaton_result_type;

   // Scoreboard holding a model of the automaton and the results still owed by the block
   class automaton_scoreboard;
      bit                trie_has[NODES*SYMS];
      logic [NODE_W-1:0] trie_child[NODES*SYMS];
      logic [NODE_W-1:0] fail_link[NODES];
      bit                end_flag[NODES];
      int unsigned       used;
      int unsigned       cursor;
      int unsigned       last_query_node;
      automaton_result_type owed[$];

      function new();
         foreach (trie_has[i]) trie_has[i] = 0;
         foreach (end_flag[i]) end_flag[i] = 0;
         foreach (fail_link[i]) fail_link[i] = '0;
         used = 1;
         cursor = 0;
         last_query_node = 0;
      endfunction

      function int unsigned step_from(int unsigned start, int unsigned sym);
         int unsigned cur;
         int unsigned steps;
         cur = start;
         steps = 0;
         if (cur >= used) return 0;
         while (cur > 0 && !trie_has[cur*SYMS+sym] && steps < NODES) begin
            cur = 32'(fail_link[cur]);
            if (cur >= used) cur = 0;
            steps++;
         end
         if (trie_has[cur*SYMS+sym]) return 32'(trie_child[cur*SYMS+sym]);
         return 0;
      endfunction

      function void relink();
         int unsigned order[NODES];
         int unsigned head;
         int unsigned tail;
         int unsigned cur;
         int unsigned c;
         int unsigned k;
         head = 0;
         tail = 0;
         fail_link[0] = '0;
         for (int s = 0; s < SYMS; s++) begin
            if (trie_has[s] && tail < NODES) begin
               c = 32'(trie_child[s]);
               fail_link[c] = '0;
               order[tail++] = c;
            end
         end
         while (head < tail) begin
            cur = order[head++];
            for (int s = 0; s < SYMS; s++) begin
               if (trie_has[cur*SYMS+s] && tail < NODES) begin
                  c = 32'(trie_child[cur*SYMS+s]);
                  k = step_from(32'(fail_link[cur]), s);
                  fail_link[c] = NODE_W'(k);
                  end_flag[c] = end_flag[c] | end_flag[k];
                  order[tail++] = c;
               end
            end
         end
      endfunction

      // an item accepted by the block: advance the model and queue its result
      function void note_item(logic [ACT_W-1:0] act, int unsigned sym, bit last,
                              int unsigned from);
         automaton_result_type r;
         int unsigned cur;
         int unsigned n;
         bit moved;
         r = '0;
         if (act == ACT_INSERT) begin
            cur = cursor;
            moved = 0;
            if (trie_has[cur*SYMS+sym]) begin
               cur = 32'(trie_child[cur*SYMS+sym]);
               moved = 1;
            end else if (used < NODES) begin
               n = used++;
               for (int s = 0; s < SYMS; s++) trie_has[n*SYMS+s] = 0;
               fail_link[n] = '0;
               end_flag[n] = 0;
               trie_has[cur*SYMS+sym] = 1;
               trie_child[cur*SYMS+sym] = NODE_W'(n);
               cur = n;
               moved = 1;
            end else begin
               r.full = 1;
            end
            if (last) begin
               if (moved) end_flag[cur] = 1;
               cursor = 0;
            end else begin
               cursor = cur;
            end
            r.node = NODE_W'(cur);
            r.match = end_flag[cur];
         end else if (act == ACT_BUILD) begin
            relink();
         end else if (act == ACT_QUERY) begin
            n = step_from(from, sym);
            r.node = NODE_W'(n);
            r.match = end_flag[n];
            last_query_node = n;
         end
         owed = {owed, r};
      endfunction

      // returns an empty string when the result matches the oldest one owed
      function string check_result(logic [RSP_DATA_W-1:0] data);
         automaton_result_type want;
         automaton_result_type got;
         if (owed.size() == 0) return $sformatf("result %h with none outstanding", data);
         want = owed.pop_front();
         got = data[NODE_W+1:0];
         if (got.node !== want.node)
            return $sformatf("next_node %0d, want %0d", got.node, want.node);
         if (got.match !== want.match)
            return $sformatf("is_match %0b, want %0b (node %0d)", got.match, want.match,
                             want.node);
         if (got.full !== want.full)
            return $sformatf("table_full %0b, want %0b", got.full, want.full);
         return "";
      endfunction
   endclass

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_tvalid = 0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // symbol[3:0], from_node[13:4], zero pad
   logic [ACT_W-1:0]      req_tuser = '0;   // action
   logic                  req_tlast = 0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // next_node[9:0], is_match[10], table_full[11]

   automaton_scoreboard sb;
   int unsigned errors = 0;
   int unsigned tx_idle = 0;
   int unsigned rx_idle = 0;
   bit          hold_rsp = 0;
   int unsigned items_sent = 0;

   always #6 clock = ~clock;

   multi_pattern_automaton_unit u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   task automatic report_mismatch(string msg);
      errors++;
      $display("mismatch at %0t: %s", $time, msg);
   endtask

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 0;
            repeat (600) @(posedge clock);
            hold_rsp = 0;
         end
         rsp_tready <= ($urandom_range(99) >= rx_idle);
      end
   end

   always @(posedge clock) begin
      string msg;
      if (!reset && rsp_tvalid && rsp_tready) begin
         msg = sb.check_result(rsp_tdata);
         if (msg != "") report_mismatch(msg);
      end
   end

   task automatic send_item(logic [ACT_W-1:0] act, int unsigned sym, bit last,
                            int unsigned from);
      while ($urandom_range(99) < tx_idle) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= act;
      req_tlast  <= last;
      req_tdata  <= {2'b00, from[NODE_W-1:0], sym[SYM_W-1:0]};
      do @(posedge clock); while (!req_tready);
      sb.note_item(act, sym, last, from);
      items_sent++;
   endtask

   task automatic send_pattern(int unsigned len, bit narrow, bit finish);
      for (int i = 0; i < len; i++)
         send_item(ACT_INSERT, narrow ? $urandom_range(3) : $urandom_range(SYMS-1),
                   finish && (i == len-1), $urandom_range(NODES-1));
   endtask

   task automatic wait_drained();
      req_tvalid <= 0;
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   initial begin
      int unsigned r;
      int unsigned from;
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 0;

      // directed: query before any build, pattern ends, overlapping suffixes, rebuild
      tx_idle = 31;
      rx_idle = 55;
      send_item(ACT_QUERY, 0, 0, 0);
      send_item(ACT_INSERT, 1, 0, 0);
      send_item(ACT_INSERT, 2, 1, 0);
      send_item(ACT_INSERT, 2, 0, 1023);
      send_item(ACT_INSERT, 3, 1, 0);
      send_item(ACT_INSERT, 15, 0, 0);
      send_item(ACT_INSERT, 1, 0, 0);
      send_item(ACT_INSERT, 2, 0, 0);
      send_item(ACT_INSERT, 3, 1, 0);
      send_item(ACT_QUERY, 2, 1, 2);
      send_item(ACT_BUILD, 0, 0, 0);
      send_item(ACT_QUERY, 3, 0, 2);
      send_item(ACT_QUERY, 1, 0, 6);
      send_item(ACT_QUERY, 2, 0, 1023);
      send_item(ACT_QUERY, 15, 1, 0);
      send_item(ACT_UNUSED, 15, 1, 1023);
      send_item(ACT_BUILD, 15, 1, 1023);
      send_item(ACT_QUERY, 3, 0, 7);
      send_item(ACT_INSERT, 0, 1, 0);

      // random: mostly well-formed patterns, queries walking the automaton
      items_sent = 0;
      hold_rsp = 1;
      while (items_sent < RANDOM_ITEMS) begin
         if (items_sent < RANDOM_ITEMS/3) begin
            tx_idle = 31;
            rx_idle = 55;
         end else if (items_sent < 2*RANDOM_ITEMS/3) begin
            tx_idle = 55;
            rx_idle = 31;
         end else begin
            tx_idle = 0;
            rx_idle = 0;
         end
         r = $urandom_range(99);
         if (r < 55) begin
            send_pattern($urandom_range(1, 8), 1'($urandom_range(1)), 1);
         end else if (r < 59) begin
            // broken pattern: no end marker, cursor left mid-trie
            send_pattern($urandom_range(1, 4), 1'($urandom_range(1)), 0);
         end else if (r < 60) begin
            send_item(ACT_BUILD, $urandom_range(SYMS-1), 1'($urandom_range(1)),
                      $urandom_range(NODES-1));
         end else if (r < 62) begin
            send_item(ACT_UNUSED, $urandom_range(SYMS-1), 1'($urandom_range(1)),
                      $urandom_range(NODES-1));
         end else begin
            case ($urandom_range(2))
               0: from = sb.last_query_node;
               1: from = $urandom_range(sb.used - 1);
               default: from = $urandom_range(NODES-1);
            endcase
            send_item(ACT_QUERY, $urandom_range(1) ? $urandom_range(3)
                      : $urandom_range(SYMS-1), 1'($urandom_range(1)), from);
         end
      end
      // final links over the full table, then queries across it
      send_item(ACT_BUILD, 0, 0, 0);
      repeat (60)
         send_item(ACT_QUERY, $urandom_range(SYMS-1), 0, $urandom_range(NODES-1));
      wait_drained();

      if (errors == 0) begin
         $display("PASS multi_pattern_automaton_unit");
      end else begin
         $display("FAIL multi_pattern_automaton_unit");
      end
      $finish;
   end

   initial begin
      #(64'd12 * 64'd6_000_000);
      $display("FAIL multi_pattern_automaton_unit");
      $finish;
   end

endmodule

@@ filelist.f @@
sv/mpa_pkg.sv
sv/multi_pattern_automaton_unit.sv
test/tb_multi_pattern_automaton_unit.sv
